### src/wir_pkg.sv
// shared types for the weighted interval regression core
package wir_pkg;

  typedef struct packed {
    logic [31:0] dissimilarity;
    logic [31:0] weight;
    logic [31:0] distance;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] transformed;
    logic        case_used;
    logic        degenerate;
    logic        last_out;
  } out_item_t;

  // one stored pair as it sits in the pair memory
  typedef struct packed {
    logic [31:0] dis;
    logic [31:0] wgt;
    logic [31:0] dst;
  } pair_t;

  localparam int PairW = $bits(pair_t);
  localparam int DivW  = 128;

  typedef struct packed {
    logic go;
    logic shift32;
  } div_ctl_t;

endpackage

### src/wir_ram.sv
// generic single-port-write ram with registered read
module wir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/wir_div.sv
// restoring divider, one quotient bit per cycle, 64-bit saturating quotient
module wir_div (
  input  logic                   clk,
  input  logic                   rst,
  input  wir_pkg::div_ctl_t      ctl,
  input  logic [wir_pkg::DivW-1:0] num,
  input  logic [wir_pkg::DivW-1:0] den,
  output logic                   done,
  output logic [63:0]            quot
);
  import wir_pkg::*;

  logic            run;
  logic [7:0]      steps;
  logic [DivW-1:0] nsh;
  logic [DivW-1:0] rem;
  logic [DivW-1:0] den_r;
  logic [63:0]     q;
  logic            sat;
  logic [DivW:0]   rsh;
  logic [DivW:0]   diff;
  logic            take;

  assign rsh  = {rem, nsh[DivW-1]};
  assign diff = rsh - {1'b0, den_r};
  assign take = rsh >= {1'b0, den_r};
  assign quot = sat ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        run   <= 1'b1;
        steps <= ctl.shift32 ? 8'd160 : 8'd128;
        nsh   <= num;
        den_r <= den;
        rem   <= '0;
        q     <= '0;
        sat   <= 1'b0;
      end else if (run) begin
        rem   <= take ? diff[DivW-1:0] : rsh[DivW-1:0];
        nsh   <= {nsh[DivW-2:0], 1'b0};
        q     <= {q[62:0], take};
        sat   <= sat | q[63];
        steps <= steps - 8'd1;
        if (steps == 8'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/wir_sqrt.sv
// integer square root of a 64-bit value, two radicand bits per cycle
module wir_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic        run;
  logic [5:0]  steps;
  logic [63:0] n_r;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [64:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        steps <= 6'd32;
        n_r   <= n;
        res   <= '0;
        bitv  <= 64'h4000_0000_0000_0000;
      end else if (run) begin
        if ({1'b0, n_r} >= trial) begin
          n_r <= n_r - trial[63:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv  <= bitv >> 2;
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/weighted_interval_regression_core.sv
// top level: pair memory, fit sequencer, shared multiplier, divider and square root
//
//   channel   signals                     handshake
//   request   req (in_item_t)             start high while busy low
//   result    result (out_item_t)         result_strobe, one cycle each
//
// loading takes one request per cycle; the request marked last_in starts the fit
// fit: a sums pass over the pairs and two divides, then the centered-sum, peak
// and scale passes, plus a free-fit divide, and an anchored pass and divide
// when the free fit fails; each result then costs a recompute of the fitted
// value, a divide and a square root
// rst is synchronous and empties the pair count; busy stays high until the last result
module weighted_interval_regression_core #(
  parameter int MAX_PAIRS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  wir_pkg::in_item_t  req,
  output logic               result_strobe,
  output wir_pkg::out_item_t result
);
  import wir_pkg::*;

  localparam int AW   = $clog2(MAX_PAIRS);
  localparam int CW   = $clog2(MAX_PAIRS + 1);
  localparam int WW   = 32 + AW;
  localparam int SXW  = 64 + AW;
  localparam int ACCW = 96 + AW;

  typedef enum logic [5:0] {
    ST_LOAD, ST_P1_RD, ST_P1_LAT, ST_P1_MY, ST_P1_ACC,
    ST_MX_GO, ST_MX_WT, ST_MY_GO, ST_MY_WT,
    ST_P2_RD, ST_P2_LAT, ST_P2_A, ST_P2_B, ST_P2_C, ST_P2_D, ST_P2_E,
    ST_CHK, ST_A0_GO, ST_A0_WT, ST_CHK2, ST_ANCH,
    ST_P3_RD, ST_P3_LAT, ST_P3_A, ST_P3_B, ST_P3_C, ST_P3_D, ST_P3_E,
    ST_P3_END, ST_A1_GO, ST_A1_WT,
    ST_FM_RD, ST_FM_LAT, ST_FM_UPD, ST_SH_LD, ST_SH,
    ST_S_RD, ST_S_LAT, ST_S_A, ST_S_B, ST_S_C, ST_S_D, ST_S_END,
    ST_O_RD, ST_O_LAT, ST_O_A, ST_O_B, ST_O_C, ST_O_D, ST_O_E, ST_O_WT, ST_O_SQ,
    ST_WM0, ST_WM1, ST_WM2, ST_AM0, ST_AM1, ST_AM2, ST_FC0, ST_FC1
  } state_t;

  state_t state, ret, fret;

  logic [CW-1:0]   cnt;
  logic [CW-1:0]   k;
  logic            last_k;
  logic [31:0]     x_r, w_r, y_r, e_r, dy_r, fp;
  logic            neg_r;
  logic [WW-1:0]   wsum;
  logic [SXW-1:0]  sx, sy;
  logic [31:0]     xmin, mx, my;
  logic [ACCW-1:0] pp, nn, dd, ssum;
  logic [63:0]     acoef, op, op2, lo;
  logic [95:0]     term;
  logic [64:0]     sres, f_r, fmax, tmpf;
  logic [5:0]      shamt;
  logic [63+CW:0]  onum;
  logic            anchored, deg;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;

  logic            ram_we;
  logic [PairW-1:0] ram_rdata;
  pair_t           rd;

  div_ctl_t        div_ctl;
  logic [DivW-1:0] div_num, div_den;
  logic            div_done;
  logic [63:0]     div_q;
  logic            sq_go, sq_done;
  logic [31:0]     sq_root;

  assign busy   = (state != ST_LOAD);
  assign last_k = (k + CW'(1)) == cnt;
  assign ram_we = (state == ST_LOAD) && start && (cnt < CW'(MAX_PAIRS));
  assign rd     = pair_t'(ram_rdata);
  assign sq_go  = (state == ST_O_WT) && div_done;

  wir_ram #(.WIDTH(PairW), .DEPTH(MAX_PAIRS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata ({req.dissimilarity, req.weight, req.distance}),
    .raddr (k[AW-1:0]),
    .rdata (ram_rdata)
  );

  wir_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  wir_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sq_go),
    .n    (div_q),
    .done (sq_done),
    .root (sq_root)
  );

  // divider operands per step
  always_comb begin
    div_ctl = '0;
    div_num = '0;
    div_den = '0;
    case (state)
      ST_MX_GO: begin
        div_ctl.go = 1'b1;
        div_num    = DivW'(sx);
        div_den    = DivW'(wsum);
      end
      ST_MY_GO: begin
        div_ctl.go = 1'b1;
        div_num    = DivW'(sy);
        div_den    = DivW'(wsum);
      end
      ST_A0_GO: begin
        div_ctl    = '{go: 1'b1, shift32: 1'b1};
        div_num    = DivW'(pp - nn);
        div_den    = DivW'(dd);
      end
      ST_A1_GO: begin
        div_ctl    = '{go: 1'b1, shift32: 1'b1};
        div_num    = DivW'(pp);
        div_den    = DivW'(dd);
      end
      ST_O_E: begin
        div_ctl.go = 1'b1;
        div_num    = DivW'({onum, 48'b0});
        div_den    = DivW'(ssum);
      end
      default: ;
    endcase
  end

  // shared 32x32 multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_P1_LAT: begin mul_a = rd.wgt;        mul_b = rd.dis; end
      ST_P1_MY:  begin mul_a = w_r;           mul_b = y_r;    end
      ST_P2_A:   begin mul_a = e_r;           mul_b = dy_r;   end
      ST_P2_B:   begin mul_a = e_r;           mul_b = e_r;    end
      ST_P3_A:   begin mul_a = e_r;           mul_b = y_r;    end
      ST_P3_B:   begin mul_a = e_r;           mul_b = e_r;    end
      ST_S_B:    begin mul_a = fp;            mul_b = fp;     end
      ST_O_B:    begin mul_a = fp;            mul_b = fp;     end
      ST_WM0:    begin mul_a = w_r;           mul_b = op[31:0];  end
      ST_WM1:    begin mul_a = w_r;           mul_b = op[63:32]; end
      ST_AM0:    begin mul_a = acoef[31:0];   mul_b = e_r;    end
      ST_AM1:    begin mul_a = acoef[63:32];  mul_b = e_r;    end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      ret           <= ST_LOAD;
      fret          <= ST_LOAD;
      cnt           <= '0;
      k             <= '0;
      anchored      <= 1'b0;
      deg           <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (start) begin
            if (cnt < CW'(MAX_PAIRS)) begin
              cnt <= cnt + CW'(1);
            end
            if (req.last_in) begin
              k        <= '0;
              wsum     <= '0;
              sx       <= '0;
              sy       <= '0;
              xmin     <= '1;
              anchored <= 1'b0;
              deg      <= 1'b0;
              state    <= ST_P1_RD;
            end
          end
        end
        ST_P1_RD: state <= ST_P1_LAT;
        ST_P1_LAT: begin
          x_r  <= rd.dis;
          w_r  <= rd.wgt;
          y_r  <= rd.dst;
          wsum <= wsum + WW'(rd.wgt);
          if (rd.dis < xmin) begin
            xmin <= rd.dis;
          end
          state <= ST_P1_MY;
        end
        ST_P1_MY: begin
          sx    <= sx + SXW'(prod);
          state <= ST_P1_ACC;
        end
        ST_P1_ACC: begin
          sy <= sy + SXW'(prod);
          if (last_k) begin
            if (wsum == '0) begin
              deg   <= 1'b1;
              k     <= '0;
              state <= ST_O_RD;
            end else begin
              state <= ST_MX_GO;
            end
          end else begin
            k     <= k + CW'(1);
            state <= ST_P1_RD;
          end
        end
        ST_MX_GO: state <= ST_MX_WT;
        ST_MX_WT: begin
          if (div_done) begin
            mx    <= div_q[31:0];
            state <= ST_MY_GO;
          end
        end
        ST_MY_GO: state <= ST_MY_WT;
        ST_MY_WT: begin
          if (div_done) begin
            my    <= div_q[31:0];
            k     <= '0;
            pp    <= '0;
            nn    <= '0;
            dd    <= '0;
            state <= ST_P2_RD;
          end
        end
        ST_P2_RD: state <= ST_P2_LAT;
        ST_P2_LAT: begin
          w_r   <= rd.wgt;
          e_r   <= (rd.dis < mx) ? mx - rd.dis : rd.dis - mx;
          dy_r  <= (rd.dst < my) ? my - rd.dst : rd.dst - my;
          neg_r <= (rd.dis < mx) != (rd.dst < my);
          state <= ST_P2_A;
        end
        ST_P2_A: state <= ST_P2_B;
        ST_P2_B: begin
          op    <= prod;
          state <= ST_P2_C;
        end
        ST_P2_C: begin
          op2   <= prod;
          ret   <= ST_P2_D;
          state <= ST_WM0;
        end
        ST_P2_D: begin
          if (neg_r) begin
            nn <= nn + ACCW'(term);
          end else begin
            pp <= pp + ACCW'(term);
          end
          op    <= op2;
          ret   <= ST_P2_E;
          state <= ST_WM0;
        end
        ST_P2_E: begin
          dd <= dd + ACCW'(term);
          if (last_k) begin
            state <= ST_CHK;
          end else begin
            k     <= k + CW'(1);
            state <= ST_P2_RD;
          end
        end
        ST_CHK: state <= (dd != '0 && pp > nn) ? ST_A0_GO : ST_ANCH;
        ST_A0_GO: state <= ST_A0_WT;
        ST_A0_WT: begin
          if (div_done) begin
            acoef <= div_q;
            if (div_q != '0) begin
              e_r   <= mx - xmin;
              ret   <= ST_CHK2;
              state <= ST_AM0;
            end else begin
              state <= ST_ANCH;
            end
          end
        end
        ST_CHK2: begin
          // free fit must stay positive at the smallest dissimilarity
          if (sres < 65'(my)) begin
            k     <= '0;
            fmax  <= '0;
            state <= ST_FM_RD;
          end else begin
            state <= ST_ANCH;
          end
        end
        ST_ANCH: begin
          anchored <= 1'b1;
          pp       <= '0;
          dd       <= '0;
          k        <= '0;
          state    <= ST_P3_RD;
        end
        ST_P3_RD: state <= ST_P3_LAT;
        ST_P3_LAT: begin
          w_r   <= rd.wgt;
          y_r   <= rd.dst;
          e_r   <= rd.dis - xmin;
          state <= ST_P3_A;
        end
        ST_P3_A: state <= ST_P3_B;
        ST_P3_B: begin
          op    <= prod;
          state <= ST_P3_C;
        end
        ST_P3_C: begin
          op2   <= prod;
          ret   <= ST_P3_D;
          state <= ST_WM0;
        end
        ST_P3_D: begin
          pp    <= pp + ACCW'(term);
          op    <= op2;
          ret   <= ST_P3_E;
          state <= ST_WM0;
        end
        ST_P3_E: begin
          dd <= dd + ACCW'(term);
          if (last_k) begin
            state <= ST_P3_END;
          end else begin
            k     <= k + CW'(1);
            state <= ST_P3_RD;
          end
        end
        ST_P3_END: begin
          if (dd == '0) begin
            deg   <= 1'b1;
            k     <= '0;
            state <= ST_O_RD;
          end else begin
            state <= ST_A1_GO;
          end
        end
        ST_A1_GO: state <= ST_A1_WT;
        ST_A1_WT: begin
          if (div_done) begin
            acoef <= div_q;
            k     <= '0;
            fmax  <= '0;
            state <= ST_FM_RD;
          end
        end
        ST_FM_RD: state <= ST_FM_LAT;
        ST_FM_LAT: begin
          x_r   <= rd.dis;
          fret  <= ST_FM_UPD;
          state <= ST_FC0;
        end
        ST_FM_UPD: begin
          if (f_r > fmax) begin
            fmax <= f_r;
          end
          if (last_k) begin
            state <= ST_SH_LD;
          end else begin
            k     <= k + CW'(1);
            state <= ST_FM_RD;
          end
        end
        ST_SH_LD: begin
          tmpf  <= fmax;
          shamt <= '0;
          state <= ST_SH;
        end
        ST_SH: begin
          if (tmpf[64:32] != '0) begin
            tmpf  <= tmpf >> 1;
            shamt <= shamt + 6'd1;
          end else begin
            k     <= '0;
            ssum  <= '0;
            state <= ST_S_RD;
          end
        end
        ST_S_RD: state <= ST_S_LAT;
        ST_S_LAT: begin
          x_r   <= rd.dis;
          w_r   <= rd.wgt;
          fret  <= ST_S_A;
          state <= ST_FC0;
        end
        ST_S_A: begin
          fp    <= 32'(f_r >> shamt);
          state <= ST_S_B;
        end
        ST_S_B: state <= ST_S_C;
        ST_S_C: begin
          op    <= prod;
          ret   <= ST_S_D;
          state <= ST_WM0;
        end
        ST_S_D: begin
          ssum <= ssum + ACCW'(term);
          if (last_k) begin
            state <= ST_S_END;
          end else begin
            k     <= k + CW'(1);
            state <= ST_S_RD;
          end
        end
        ST_S_END: begin
          if (ssum == '0) begin
            deg <= 1'b1;
          end
          k     <= '0;
          state <= ST_O_RD;
        end
        ST_O_RD: begin
          if (deg) begin
            result        <= '{transformed: '0, case_used: anchored,
                               degenerate: 1'b1, last_out: last_k};
            result_strobe <= 1'b1;
            if (last_k) begin
              cnt   <= '0;
              state <= ST_LOAD;
            end else begin
              k <= k + CW'(1);
            end
          end else begin
            state <= ST_O_LAT;
          end
        end
        ST_O_LAT: begin
          x_r   <= rd.dis;
          fret  <= ST_O_A;
          state <= ST_FC0;
        end
        ST_O_A: begin
          fp    <= 32'(f_r >> shamt);
          state <= ST_O_B;
        end
        ST_O_B: state <= ST_O_C;
        ST_O_C: begin
          op    <= prod;
          state <= ST_O_D;
        end
        ST_O_D: begin
          onum  <= (64 + CW)'(op) * (64 + CW)'(cnt);
          state <= ST_O_E;
        end
        ST_O_E: state <= ST_O_WT;
        ST_O_WT: begin
          if (div_done) begin
            state <= ST_O_SQ;
          end
        end
        ST_O_SQ: begin
          if (sq_done) begin
            result        <= '{transformed: sq_root, case_used: anchored,
                               degenerate: 1'b0, last_out: last_k};
            result_strobe <= 1'b1;
            if (last_k) begin
              cnt   <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + CW'(1);
              state <= ST_O_RD;
            end
          end
        end
        // weight times a 64-bit operand, two partial products
        ST_WM0: state <= ST_WM1;
        ST_WM1: begin
          lo    <= prod;
          state <= ST_WM2;
        end
        ST_WM2: begin
          term  <= {prod, 32'b0} + 96'(lo);
          state <= ret;
        end
        // (coefficient * e_r) >> 32
        ST_AM0: state <= ST_AM1;
        ST_AM1: begin
          lo    <= prod;
          state <= ST_AM2;
        end
        ST_AM2: begin
          sres  <= 65'(prod) + 65'(lo[63:32]);
          state <= ret;
        end
        // fitted value for x_r
        ST_FC0: begin
          if (anchored) begin
            e_r   <= x_r - xmin;
            neg_r <= 1'b0;
          end else if (x_r < mx) begin
            e_r   <= mx - x_r;
            neg_r <= 1'b1;
          end else begin
            e_r   <= x_r - mx;
            neg_r <= 1'b0;
          end
          ret   <= ST_FC1;
          state <= ST_AM0;
        end
        ST_FC1: begin
          if (anchored) begin
            f_r <= sres;
          end else if (neg_r) begin
            f_r <= 65'(my) - sres;
          end else begin
            f_r <= 65'(my) + sres;
          end
          state <= fret;
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last_out |-> !busy)
    else $error("block still busy after the last result");

  a_idle_only_after_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !busy |-> result.last_out)
    else $error("block went idle before the last result");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.degenerate |-> result.transformed == '0)
    else $error("degenerate result is not zero");

  a_no_write_in_fit: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ram_we)
    else $error("pair memory written during a fit");

endmodule
